// ===== hdl/sha256_byte_stream_hasher_top_defines.svh =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher: assertion macros
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_TOP_DEFINES_SVH

// same-cycle implication
`define SHS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("shs: same-cycle check failed");

// next-cycle implication
`define SHS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("shs: next-cycle check failed");

`endif

// ===== hdl/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher package
// Types, round constants, initial hash values and round functions.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned LEN_POS     = 56;
    localparam int unsigned ROUNDS      = 64;
    localparam logic [7:0]  PAD_MARK    = 8'h80;

    typedef enum logic [1:0] {
        CMD_ABSORB     = 2'd0,
        CMD_ABSORB_FIN = 2'd1,
        CMD_FINISH     = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_FOLD,
        ST_DONE
    } t_state;

    // control from the sequencer to the schedule and round units
    typedef struct packed {
        logic       byte_en;   // shift one byte into the block
        logic [7:0] byte_val;
        logic       sched_en;  // produce W[t] + K[t]
        logic [5:0] t;
        logic       wload;     // working <= chain
        logic       round_en;  // one compression round
        logic       fold;      // chain += working
        logic       init;      // chain <= initial values
    } t_ctl;

    localparam logic [31:0] K_TAB [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

    function automatic logic [31:0] f_ch(input logic [31:0] e, input logic [31:0] f,
                                         input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] f_maj(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/shs_sched.sv =====
// ----------------------------------------------------------------------------
// SHA-256 block buffer and message schedule
// Sixteen-word shift line: bytes shift in while a block fills, then the
// same line expands the schedule one word per step and hands out W + K.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_sched (
    input  wire logic          i_clk,
    input  wire shs_pkg::t_ctl i_ctl,
    output logic [31:0]        o_wk
);

    logic [31:0] r_win [16];   // r_win[0] holds the oldest word
    logic [31:0] r_wk;
    logic [31:0] w_new;
    logic [31:0] w_wt;

    assign w_new = r_win[0] + shs_pkg::small_sigma0(r_win[1]) + r_win[9]
                 + shs_pkg::small_sigma1(r_win[14]);
    // first sixteen steps just rotate the block words out
    assign w_wt  = (i_ctl.t[5:4] == 2'b00) ? r_win[0] : w_new;

    always_ff @(posedge i_clk) begin
        if (i_ctl.byte_en) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= {r_win[i][23:0], r_win[i+1][31:24]};
            end
            r_win[15] <= {r_win[15][23:0], i_ctl.byte_val};
        end else if (i_ctl.sched_en) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= w_wt;
            r_wk      <= w_wt + shs_pkg::K_TAB[i_ctl.t];
        end
    end

    assign o_wk = r_wk;

endmodule

`default_nettype wire

// ===== hdl/shs_round.sv =====
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Chaining words and the eight working words; one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_round (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire shs_pkg::t_ctl i_ctl,
    input  wire logic [31:0]   i_wk,
    output logic [31:0]        o_chain [8]
);

    logic [31:0] r_chain [8];
    logic [31:0] r_work  [8];
    logic [31:0] w_t1;
    logic [31:0] w_t2;

    assign w_t1 = r_work[7] + shs_pkg::big_sigma1(r_work[4])
                + shs_pkg::f_ch(r_work[4], r_work[5], r_work[6]) + i_wk;
    assign w_t2 = shs_pkg::big_sigma0(r_work[0])
                + shs_pkg::f_maj(r_work[0], r_work[1], r_work[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= shs_pkg::IV_TAB[i];
            end
        end else if (i_ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= r_chain[i] + r_work[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wload) begin
            r_work <= r_chain;
        end else if (i_ctl.round_en) begin
            r_work[7] <= r_work[6];
            r_work[6] <= r_work[5];
            r_work[5] <= r_work[4];
            r_work[4] <= r_work[3] + w_t1;
            r_work[3] <= r_work[2];
            r_work[2] <= r_work[1];
            r_work[1] <= r_work[0];
            r_work[0] <= w_t1 + w_t2;
        end
    end

    assign o_chain = r_chain;

endmodule

`default_nettype wire

// ===== hdl/sha256_byte_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// SHA-256 byte stream hasher
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------------
//  in      | in        | i_valid / o_stall   | i_cmd, i_data_byte
//  out     | out       | o_valid / i_stall   | o_digest_part0 .. o_digest_part3
//
// A plain byte is absorbed without a stall; the 64th byte of a block adds a
// compression (65 schedule/round steps plus one fold), set by the single round
// unit. Finish shifts padding one byte a cycle up to a block boundary and
// compresses, twice when the length spills, then loads the digest. The input
// stalls for all of that; the digest register lets the next message start
// while it waits.
// Reset is synchronous and restores the initial hash values.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_byte_stream_hasher_top_defines.svh"

module sha256_byte_stream_hasher_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_stall,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [63:0]      o_digest_part0,
    output logic [63:0]      o_digest_part1,
    output logic [63:0]      o_digest_part2,
    output logic [63:0]      o_digest_part3
);

    shs_pkg::t_state r_state, n_state;
    shs_pkg::t_ctl   w_ctl;
    shs_pkg::t_cmd   w_cmd;

    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic [6:0]  r_cnt;
    logic        r_fin;      // finish requested, digest still owed
    logic        r_mark;     // 0x80 marker not yet placed
    logic        r_len_ok;   // length goes into the current block
    logic        r_last;     // running compression is the final one
    logic        w_acc;
    logic        w_absorb;
    logic        w_finreq;
    logic        w_wrap;
    logic        w_fit;
    logic        w_out_free;
    logic [7:0]  w_pad_byte;
    logic [31:0] w_wk;
    logic [31:0] w_chain [8];

    assign w_cmd      = shs_pkg::t_cmd'(i_cmd);
    assign w_acc      = i_valid && !o_stall;
    assign w_absorb   = w_acc && (w_cmd == shs_pkg::CMD_ABSORB ||
                                  w_cmd == shs_pkg::CMD_ABSORB_FIN);
    assign w_finreq   = w_acc && (w_cmd == shs_pkg::CMD_ABSORB_FIN ||
                                  w_cmd == shs_pkg::CMD_FINISH);
    assign w_wrap     = (r_fill == 6'(shs_pkg::BLOCK_BYTES - 1));
    assign w_out_free = !o_valid || !i_stall;
    // length fits when the marker lands at or before byte LEN_POS - 1
    assign w_fit      = r_mark ? (r_fill < 6'(shs_pkg::LEN_POS)) : r_len_ok;

    always_comb begin
        if (r_mark) begin
            w_pad_byte = shs_pkg::PAD_MARK;
        end else if (r_len_ok && r_fill >= 6'(shs_pkg::LEN_POS)) begin
            w_pad_byte = r_bits[{3'd7 - r_fill[2:0], 3'b000} +: 8];
        end else begin
            w_pad_byte = 8'h00;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shs_pkg::ST_IDLE: begin
                if (w_absorb && w_wrap) begin
                    n_state = shs_pkg::ST_COMP;
                end else if (w_finreq) begin
                    n_state = shs_pkg::ST_PAD;
                end
            end
            shs_pkg::ST_PAD: begin
                if (w_wrap) begin
                    n_state = shs_pkg::ST_COMP;
                end
            end
            shs_pkg::ST_COMP: begin
                if (r_cnt == 7'(shs_pkg::ROUNDS)) begin
                    n_state = shs_pkg::ST_FOLD;
                end
            end
            shs_pkg::ST_FOLD: begin
                if (r_last) begin
                    n_state = shs_pkg::ST_DONE;
                end else if (r_fin) begin
                    n_state = shs_pkg::ST_PAD;
                end else begin
                    n_state = shs_pkg::ST_IDLE;
                end
            end
            shs_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = shs_pkg::ST_IDLE;
                end
            end
            default: n_state = shs_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_stall        = 1'b1;
        w_ctl          = '0;
        w_ctl.t        = r_cnt[5:0];
        w_ctl.byte_val = i_data_byte;
        unique case (r_state)
            shs_pkg::ST_IDLE: begin
                o_stall       = 1'b0;
                w_ctl.byte_en = w_absorb;
            end
            shs_pkg::ST_PAD: begin
                w_ctl.byte_en  = 1'b1;
                w_ctl.byte_val = w_pad_byte;
            end
            shs_pkg::ST_COMP: begin
                // schedule runs one step ahead of the rounds
                w_ctl.sched_en = !r_cnt[6];
                w_ctl.wload    = (r_cnt == 7'd0);
                w_ctl.round_en = (r_cnt != 7'd0);
            end
            shs_pkg::ST_FOLD: begin
                w_ctl.fold = 1'b1;
            end
            shs_pkg::ST_DONE: begin
                w_ctl.init = w_out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= shs_pkg::ST_IDLE;
            r_fill   <= '0;
            r_bits   <= '0;
            r_cnt    <= '0;
            r_fin    <= 1'b0;
            r_mark   <= 1'b0;
            r_len_ok <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_ctl.byte_en) begin
                r_fill <= r_fill + 6'd1;
            end
            if (w_ctl.init) begin
                r_bits <= '0;
            end else if (w_absorb) begin
                r_bits <= r_bits + 64'd8;
            end
            r_cnt <= (r_state == shs_pkg::ST_COMP) ? r_cnt + 7'd1 : 7'd0;
            if (r_state == shs_pkg::ST_IDLE && w_finreq) begin
                r_fin  <= 1'b1;
                r_mark <= 1'b1;
            end
            if (r_state == shs_pkg::ST_PAD) begin
                r_mark <= 1'b0;
                if (w_wrap) begin
                    r_last   <= w_fit;
                    r_len_ok <= 1'b1;
                end else begin
                    r_len_ok <= w_fit;
                end
            end
            if (w_ctl.init) begin
                r_fin  <= 1'b0;
                r_last <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_ctl.init) begin
            o_valid <= 1'b1;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.init) begin
            o_digest_part0 <= {w_chain[0], w_chain[1]};
            o_digest_part1 <= {w_chain[2], w_chain[3]};
            o_digest_part2 <= {w_chain[4], w_chain[5]};
            o_digest_part3 <= {w_chain[6], w_chain[7]};
        end
    end

    shs_sched u_sched (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_wk  (w_wk)
    );

    shs_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_wk    (w_wk),
        .o_chain (w_chain)
    );

    `SHS_ASSERT_IMP(a_done_aligned, r_state == shs_pkg::ST_DONE, r_fill == 6'd0)
    `SHS_ASSERT_IMP(a_result_from_done, $rose(o_valid), $past(r_state) == shs_pkg::ST_DONE)
    `SHS_ASSERT_NXT(a_last_round_folds,
        r_state == shs_pkg::ST_COMP && r_cnt == 7'(shs_pkg::ROUNDS),
        r_state == shs_pkg::ST_FOLD)
    `SHS_ASSERT_IMP(a_mark_needs_fin, r_mark, r_fin)

endmodule

`default_nettype wire

// ===== tb/sv/tb_sha256_byte_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// Testbench for the SHA-256 byte stream hasher
// Sends a table of short known messages, then random messages of mixed
// lengths with noise requests in between. A local SHA-256 model predicts each
// digest the table does not give. Both handshake sides idle at random, with
// one long output hold-off and one input pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sha256_byte_stream_hasher_top;

    typedef struct packed {
        logic [63:0] part0;
        logic [63:0] part1;
        logic [63:0] part2;
        logic [63:0] part3;
    } t_digest;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       typed;   // want holds a known digest
        t_digest    want;
    } t_stim_row;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned RAND_ITEMS = 400;
    localparam int unsigned DIR_ROWS = 16;
    localparam int unsigned DIR_MSGS = 7;
    localparam int unsigned PAUSE_ITEMS = 100;

    localparam t_digest EMPTY_DIGEST = '{
        64'he3b0c44298fc1c14, 64'h9afbf4c8996fb924,
        64'h27ae41e4649b934c, 64'ha495991b7852b855
    };
    localparam t_digest ABC_DIGEST = '{
        64'hba7816bf8f01cfea, 64'h414140de5dae2223,
        64'hb00361a396177a9c, 64'hb410ff61f20015ad
    };

    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        '{shs_pkg::CMD_FINISH,     8'ha5, 1'b1, EMPTY_DIGEST},
        '{CMD_RESERVED,            8'hff, 1'b0, '0},
        '{shs_pkg::CMD_ABSORB,     8'h61, 1'b0, '0},
        '{shs_pkg::CMD_ABSORB,     8'h62, 1'b0, '0},
        '{CMD_RESERVED,            8'h00, 1'b0, '0},
        '{shs_pkg::CMD_ABSORB_FIN, 8'h63, 1'b1, ABC_DIGEST},
        '{shs_pkg::CMD_ABSORB_FIN, 8'h00, 1'b0, '0},
        '{shs_pkg::CMD_ABSORB_FIN, 8'hff, 1'b0, '0},
        '{shs_pkg::CMD_ABSORB,     8'hff, 1'b0, '0},
        '{shs_pkg::CMD_ABSORB,     8'h00, 1'b0, '0},
        '{shs_pkg::CMD_ABSORB,     8'h55, 1'b0, '0},
        '{shs_pkg::CMD_ABSORB,     8'haa, 1'b0, '0},
        '{shs_pkg::CMD_FINISH,     8'h5a, 1'b0, '0},
        '{shs_pkg::CMD_FINISH,     8'hff, 1'b1, EMPTY_DIGEST},
        '{CMD_RESERVED,            8'h80, 1'b0, '0},
        '{shs_pkg::CMD_FINISH,     8'h00, 1'b1, EMPTY_DIGEST}
    };

    // message lengths around the one- and two-block padding boundaries
    localparam int unsigned LEN_EDGES [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

    localparam logic [31:0] HASH_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONSTS [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_cmd = shs_pkg::CMD_ABSORB;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_digest_part0;
    logic [63:0] o_digest_part1;
    logic [63:0] o_digest_part2;
    logic [63:0] o_digest_part3;

    // hash model state
    logic [31:0] hash_words [8];
    logic [7:0]  blk_buf [64];
    int unsigned blk_fill;
    logic [63:0] bit_count;

    t_digest     pending_digests [$];
    int unsigned err_count = 0;
    int unsigned items_sent = 0;
    int unsigned msgs_done = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_left = 0;
    bit          random_phase = 1'b0;
    bit          hold_done = 1'b0;
    bit          calm = 1'b0;

    sha256_byte_stream_hasher_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_cmd          (i_cmd),
        .i_data_byte    (i_data_byte),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_part0 (o_digest_part0),
        .o_digest_part1 (o_digest_part1),
        .o_digest_part2 (o_digest_part2),
        .o_digest_part3 (o_digest_part3)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++) hash_words[i] = HASH_START[i];
        blk_fill = 0;
        bit_count = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_buf[4*t], blk_buf[4*t+1], blk_buf[4*t+2], blk_buf[4*t+3]};
        for (int t = 16; t < 64; t++)
            w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                 + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
        for (int t = 0; t < 64; t++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_CONSTS[t] + w[t];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
        hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
    endfunction

    // returns 1 when the request finishes a message; dig then holds its digest
    function automatic bit hash_item(input logic [1:0] cmd, input logic [7:0] data,
                                     output t_digest dig);
        int unsigned pos;
        dig = '0;
        if (cmd == CMD_RESERVED) return 1'b0;
        if (cmd != shs_pkg::CMD_FINISH) begin
            blk_buf[blk_fill] = data;
            bit_count += 64'd8;
            blk_fill = (blk_fill + 1) % 64;
            if (blk_fill == 0) sha_compress();
        end
        if (cmd == shs_pkg::CMD_ABSORB) return 1'b0;
        pos = blk_fill;
        blk_buf[pos] = 8'h80;
        pos++;
        // no room for the length: pad out this block and start another
        if (pos > 56) begin
            while (pos < 64) begin
                blk_buf[pos] = 8'h00;
                pos++;
            end
            sha_compress();
            pos = 0;
        end
        while (pos < 56) begin
            blk_buf[pos] = 8'h00;
            pos++;
        end
        for (int k = 0; k < 8; k++) blk_buf[56+k] = 8'(bit_count >> (56 - 8*k));
        sha_compress();
        dig.part0 = {hash_words[0], hash_words[1]};
        dig.part1 = {hash_words[2], hash_words[3]};
        dig.part2 = {hash_words[4], hash_words[5]};
        dig.part3 = {hash_words[6], hash_words[7]};
        hash_restart();
        return 1'b1;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_digest();
        t_digest want;
        if (pending_digests.size() == 0) begin
            flag_error("digest arrived with none expected");
            return;
        end
        want = pending_digests.pop_front();
        if (o_digest_part0 !== want.part0)
            flag_error($sformatf("part0 got %h want %h", o_digest_part0, want.part0));
        if (o_digest_part1 !== want.part1)
            flag_error($sformatf("part1 got %h want %h", o_digest_part1, want.part1));
        if (o_digest_part2 !== want.part2)
            flag_error($sformatf("part2 got %h want %h", o_digest_part2, want.part2));
        if (o_digest_part3 !== want.part3)
            flag_error($sformatf("part3 got %h want %h", o_digest_part3, want.part3));
    endtask

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                             input logic typed, input t_digest want);
        t_digest dig;
        calm = random_phase && items_sent >= DIR_ROWS + 150 && items_sent < DIR_ROWS + 300;
        while (!calm && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= cmd;
        i_data_byte <= data;
        do @(posedge i_clk); while (o_stall);
        if (cmd != CMD_RESERVED) items_sent++;
        if (hash_item(cmd, data, dig)) begin
            msgs_done++;
            pending_digests.push_back(typed ? want : dig);
        end
    endtask

    task automatic send_message(input int unsigned len);
        bit byte_fin;
        byte_fin = (len > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < int'(len) - int'(byte_fin); i++) begin
            if ($urandom_range(99) < 4)
                send_item(CMD_RESERVED, 8'($urandom_range(255)), 1'b0, '0);
            send_item(shs_pkg::CMD_ABSORB, 8'($urandom_range(255)), 1'b0, '0);
        end
        if (byte_fin) send_item(shs_pkg::CMD_ABSORB_FIN, 8'($urandom_range(255)), 1'b0, '0);
        else send_item(shs_pkg::CMD_FINISH, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(99);
        // the first messages stay short so the output hold-off backs up the block
        if (msgs_done < DIR_MSGS + 6) return $urandom_range(3);
        if (r < 72) return $urandom_range(12);
        if (r < 88) return LEN_EDGES[$urandom_range(9)];
        return $urandom_range(130, 100);
    endfunction

    // output side: checks digests, stalls at random, one long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) check_digest();
            if (random_phase && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 27);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        bit paused;
        paused = 1'b0;
        hash_restart();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIR_TABLE[i].cmd, DIR_TABLE[i].data, DIR_TABLE[i].typed,
                      DIR_TABLE[i].want);

        random_phase = 1'b1;
        while (items_sent < DIR_ROWS + RAND_ITEMS) begin
            // input pause: let every outstanding digest drain
            if (!paused && items_sent >= DIR_ROWS + PAUSE_ITEMS) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_digests.size() != 0) @(posedge i_clk);
            end
            send_message(pick_length());
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_digests.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/shs_pkg.sv
hdl/shs_sched.sv
hdl/shs_round.sv
hdl/sha256_byte_stream_hasher_top.sv
tb/sv/tb_sha256_byte_stream_hasher_top.sv
